[sv/rpn_stack_calculator_top_assert.svh]
// Assertion macros for the RPN stack calculator
`ifndef RPN_STACK_CALCULATOR_TOP_ASSERT_SVH
`define RPN_STACK_CALCULATOR_TOP_ASSERT_SVH

// same-cycle implication
`define RSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rsc_pkg.sv]
// Shared types and constants for the RPN stack calculator
`default_nettype none

package rsc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 16;
    localparam int OPC_W           = 3;
    localparam int DEPTH_W         = 7;

    localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPC_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPC_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OPC_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OPC_W-1:0] OP_SHOW = 3'd5;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [DATA_W-1:0] operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic                     underflow_flag;
        logic                     overflow_flag;
        logic                     divide_zero_flag;
        logic                     bad_opcode_flag;
    } t_out_item;

    typedef struct packed {
        logic underflow;
        logic overflow;
        logic divide_zero;
        logic bad_opcode;
    } t_flags;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_ITER,
        ALU_SIGN
    } t_alu_state;

    typedef enum logic [2:0] {
        S_SEQ_IDLE,
        S_SEQ_READ,
        S_SEQ_WAIT,
        S_SEQ_RESP
    } t_seq_state;

endpackage

`default_nettype wire

[sv/rsc_stack_ram.sv]
// Operand stack storage: one write port, one registered read port
`default_nettype none

module rsc_stack_ram #(
    parameter int DEPTH = rsc_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [rsc_pkg::DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [rsc_pkg::DATA_W-1:0] o_rdata
);
    import rsc_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/rsc_alu.sv]
// Shared arithmetic unit: add/sub in one step, shift-add multiply, restoring divide
`default_nettype none

module rsc_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rsc_pkg::t_alu_req i_req,
    output rsc_pkg::t_alu_rsp      o_rsp
);
    import rsc_pkg::*;

    localparam int CW = $clog2(DATA_W);

    t_alu_state        r_state, n_state;
    t_alu_op           r_op, n_op;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_y, n_y;
    logic              r_neg, n_neg;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_res, n_res;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_neg   = r_neg;
        n_done  = 1'b0;
        n_res   = r_res;
        w_trial = {r_acc, r_x[DATA_W-1]};
        w_diff  = w_trial - {1'b0, r_y};
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_cnt = '1;
                    n_acc = '0;
                    case (i_req.op)
                        ALU_ADD: begin
                            n_res  = i_req.a + i_req.b;
                            n_done = 1'b1;
                        end
                        ALU_SUB: begin
                            n_res  = i_req.a - i_req.b;
                            n_done = 1'b1;
                        end
                        ALU_MUL: begin
                            n_x     = i_req.a;
                            n_y     = i_req.b;
                            n_state = ALU_ITER;
                        end
                        ALU_DIV: begin
                            n_x     = i_req.a[DATA_W-1] ? -i_req.a : i_req.a;
                            n_y     = i_req.b[DATA_W-1] ? -i_req.b : i_req.b;
                            n_neg   = i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
                            n_state = ALU_ITER;
                        end
                        default: begin
                            n_state = ALU_IDLE;
                        end
                    endcase
                end
            end
            ALU_ITER: begin
                if (r_op == ALU_MUL) begin
                    if (r_y[0]) begin
                        n_acc = r_acc + r_x;
                    end
                    n_x = {r_x[DATA_W-2:0], 1'b0};
                    n_y = {1'b0, r_y[DATA_W-1:1]};
                end else if (!w_diff[DATA_W]) begin
                    n_acc = w_diff[DATA_W-1:0];
                    n_x   = {r_x[DATA_W-2:0], 1'b1};
                end else begin
                    n_acc = w_trial[DATA_W-1:0];
                    n_x   = {r_x[DATA_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = ALU_SIGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ALU_SIGN: begin
                if (r_op == ALU_MUL) begin
                    n_res = r_acc;
                end else begin
                    n_res = r_neg ? -r_x : r_x;
                end
                n_done  = 1'b1;
                n_state = ALU_IDLE;
            end
            default: begin
                n_state = ALU_IDLE;
            end
        endcase
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

[sv/rpn_stack_calculator_top.sv]
// RPN stack calculator: sequencer, top-of-stack register, stack RAM and shared ALU
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+---------------------------------
//  command  | start, busy, i_item              | edge with start high, busy low
//  result   | o_result_valid, o_result         | one-cycle strobe, cannot stall
//
// The strobe is registered from the response state. Push, show and unknown opcode go
// there directly; divide by zero passes the read state first; add and subtract wait
// for the ALU; multiply and divide wait for the 16 single-bit steps of the shared ALU.
// busy drops in the strobe cycle, so the next transaction may be taken there.
// Synchronous active-low reset empties the stack; stack RAM contents are not cleared.
`default_nettype none

module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rsc_pkg::t_in_item i_item,
    output logic                   o_result_valid,
    output rsc_pkg::t_out_item     o_result
);
    import rsc_pkg::*;

    `include "rpn_stack_calculator_top_assert.svh"

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

    t_seq_state        r_state, n_state;
    logic [SPW-1:0]    r_sp, n_sp;
    logic [DATA_W-1:0] r_tos, n_tos;
    logic [OPC_W-1:0]  r_op, n_op;
    t_flags            r_flags, n_flags;
    logic              r_vld, n_vld;
    t_out_item         r_out, n_out;

    logic [SPW-1:0]    w_sp_m1;
    logic [AW-1:0]     w_sp_m2;
    logic              w_we;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;

    assign w_sp_m1  = r_sp - 1'b1;
    assign w_sp_m2  = AW'(r_sp - SP_TWO);
    assign w_b      = (r_sp != '0) ? r_tos : '0;
    assign w_a      = (r_sp >= SP_TWO) ? w_rdata : '0;

    rsc_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_sp_m1[AW-1:0]),
        .i_wdata (r_tos),
        .i_raddr (w_sp_m2),
        .o_rdata (w_rdata)
    );

    rsc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .o_rsp   (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SEQ_IDLE;
            r_sp    <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos   <= n_tos;
        r_op    <= n_op;
        r_flags <= n_flags;
        r_out   <= n_out;
    end

    always_comb begin
        n_state         = r_state;
        n_sp            = r_sp;
        n_tos           = r_tos;
        n_op            = r_op;
        n_flags         = r_flags;
        n_vld           = 1'b0;
        n_out           = r_out;
        w_we            = 1'b0;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = ALU_ADD;
        w_alu_req.a     = w_a;
        w_alu_req.b     = w_b;
        case (r_state)
            S_SEQ_IDLE: begin
                if (start) begin
                    n_op    = i_item.opcode;
                    n_flags = '0;
                    n_state = S_SEQ_RESP;
                    case (i_item.opcode)
                        OP_PUSH: begin
                            if (r_sp < SP_FULL) begin
                                w_we  = (r_sp != '0);
                                n_tos = i_item.operand_value;
                                n_sp  = r_sp + 1'b1;
                            end else begin
                                n_flags.overflow = 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            n_state = S_SEQ_READ;
                        end
                        OP_SHOW: begin
                            n_flags.underflow = (r_sp == '0);
                        end
                        default: begin
                            n_flags.bad_opcode = 1'b1;
                        end
                    endcase
                end
            end
            S_SEQ_READ: begin
                if (r_op == OP_DIV && w_b == '0) begin
                    n_flags.divide_zero = 1'b1;
                    n_flags.underflow   = (r_sp == '0);
                    if (r_sp != '0) begin
                        n_sp  = w_sp_m1;
                        n_tos = w_rdata;
                    end
                    n_state = S_SEQ_RESP;
                end else begin
                    n_flags.underflow = (r_sp < SP_TWO);
                    w_alu_req.start   = 1'b1;
                    case (r_op)
                        OP_ADD:  w_alu_req.op = ALU_ADD;
                        OP_SUB:  w_alu_req.op = ALU_SUB;
                        OP_MUL:  w_alu_req.op = ALU_MUL;
                        default: w_alu_req.op = ALU_DIV;
                    endcase
                    n_state = S_SEQ_WAIT;
                end
            end
            S_SEQ_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_tos   = w_alu_rsp.result;
                    n_sp    = (r_sp >= SP_TWO) ? w_sp_m1 : SPW'(1);
                    n_state = S_SEQ_RESP;
                end
            end
            S_SEQ_RESP: begin
                n_out.top_value        = (r_sp != '0) ? r_tos : '0;
                n_out.stack_depth      = DEPTH_W'(r_sp);
                n_out.underflow_flag   = r_flags.underflow;
                n_out.overflow_flag    = r_flags.overflow;
                n_out.divide_zero_flag = r_flags.divide_zero;
                n_out.bad_opcode_flag  = r_flags.bad_opcode;
                n_vld                  = 1'b1;
                n_state                = S_SEQ_IDLE;
            end
            default: begin
                n_state = S_SEQ_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_SEQ_IDLE);
    assign o_result_valid = r_vld;
    assign o_result       = r_out;

    `RSC_ASSERT_NOW(a_strobe_not_busy, i_clk, i_rst_n, o_result_valid, !busy, "result while busy")
    `RSC_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy, "accept ignored")
    `RSC_ASSERT_NOW(a_sp_in_range, i_clk, i_rst_n, 1'b1, r_sp <= SP_FULL, "stack pointer past depth")
    `RSC_ASSERT_NOW(a_alu_done_in_wait, i_clk, i_rst_n, w_alu_rsp.done, r_state == S_SEQ_WAIT, "stray ALU result")

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the RPN stack calculator: stimulus, predictor, result checks
module tb;
    import rsc_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNKNOWN_6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_UNKNOWN_7 = 3'd7;
    localparam int               TAIL_CYCLES  = 40;
    localparam int               CALC_AW      = $clog2(STACK_DEPTH_DEF);

    logic      i_clk          = 1'b0;
    logic      i_rst_n        = 1'b0;
    logic      start          = 1'b0;
    t_in_item  i_item         = '0;
    logic      busy;
    logic      o_result_valid;
    t_out_item o_result;

    rpn_stack_calculator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // predicted stack contents
    logic [DATA_W-1:0] calc_stack [STACK_DEPTH_DEF];
    int                calc_depth = 0;
    logic              calc_under;
    logic              calc_over;

    t_out_item         pending_results [$];
    int                mismatch_count = 0;
    bit                sender_idles   = 1'b1;

    function automatic void calc_push(input logic [DATA_W-1:0] v);
        if (calc_depth < STACK_DEPTH_DEF) begin
            calc_stack[calc_depth[CALC_AW-1:0]] = v;
            calc_depth++;
        end else begin
            calc_over = 1'b1;
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] calc_pop();
        if (calc_depth > 0) begin
            calc_depth--;
            return calc_stack[calc_depth[CALC_AW-1:0]];
        end
        calc_under = 1'b1;
        return '0;
    endfunction

    function automatic t_out_item predict_token(input t_in_item tok);
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        int                       quot;
        int                       top_idx;
        t_out_item                r;
        r          = '0;
        calc_under = 1'b0;
        calc_over  = 1'b0;
        case (tok.opcode)
            OP_PUSH: calc_push(tok.operand_value);
            OP_ADD: begin
                rhs = calc_pop();
                lhs = calc_pop();
                calc_push(lhs + rhs);
            end
            OP_SUB: begin
                rhs = calc_pop();
                lhs = calc_pop();
                calc_push(lhs - rhs);
            end
            OP_MUL: begin
                rhs = calc_pop();
                lhs = calc_pop();
                calc_push(lhs * rhs);
            end
            OP_DIV: begin
                rhs = calc_pop();
                if (rhs != 0) begin
                    lhs  = calc_pop();
                    quot = int'(lhs) / int'(rhs);
                    calc_push(quot[DATA_W-1:0]);
                end else begin
                    r.divide_zero_flag = 1'b1;
                end
            end
            OP_SHOW: begin
                if (calc_depth == 0) calc_under = 1'b1;
            end
            default: r.bad_opcode_flag = 1'b1;
        endcase
        if (calc_depth > 0) begin
            top_idx     = calc_depth - 1;
            r.top_value = calc_stack[top_idx[CALC_AW-1:0]];
        end
        r.stack_depth    = calc_depth[DEPTH_W-1:0];
        r.underflow_flag = calc_under;
        r.overflow_flag  = calc_over;
        return r;
    endfunction

    task automatic check_field(input string field, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, got %0d", field, expv, actv);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no transaction outstanding");
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("top_value", int'(exp_r.top_value), int'(o_result.top_value));
                check_field("stack_depth", int'(exp_r.stack_depth),
                            int'(o_result.stack_depth));
                check_field("underflow_flag", int'(exp_r.underflow_flag),
                            int'(o_result.underflow_flag));
                check_field("overflow_flag", int'(exp_r.overflow_flag),
                            int'(o_result.overflow_flag));
                check_field("divide_zero_flag", int'(exp_r.divide_zero_flag),
                            int'(o_result.divide_zero_flag));
                check_field("bad_opcode_flag", int'(exp_r.bad_opcode_flag),
                            int'(o_result.bad_opcode_flag));
            end
        end
    end

    // called just after a rising edge; drives at falling edges
    task automatic send_token(input logic [OPC_W-1:0] opc, input logic [DATA_W-1:0] val);
        t_in_item tok;
        tok.opcode        = opc;
        tok.operand_value = val;
        @(negedge i_clk);
        while (sender_idles && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= tok;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_token(tok));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            default: return DATA_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // adds fold the stack down to one entry, divides then clear it
    task automatic empty_stack();
        while (calc_depth > 1) send_token(OP_ADD, pick_operand());
        while (calc_depth > 0) send_token(OP_DIV, pick_operand());
    endtask

    task automatic test_empty_stack_faults();
        send_token(OP_SHOW, 16'hFFFF);
        send_token(OP_DIV, 16'h0000);
        send_token(OP_ADD, 16'h7FFF);
        send_token(OP_SUB, 16'h8000);
        send_token(OP_MUL, pick_operand());
        send_token(OP_UNKNOWN_6, 16'hFFFF);
        send_token(OP_UNKNOWN_7, 16'h0000);
        send_token(OP_DIV, pick_operand());
        send_token(OP_SHOW, pick_operand());
        send_token(OP_PUSH, 16'h0005);
        send_token(OP_DIV, pick_operand());
        send_token(OP_DIV, pick_operand());
    endtask

    task automatic test_arithmetic_corners();
        send_token(OP_PUSH, 16'h7FFF);
        send_token(OP_PUSH, 16'h0001);
        send_token(OP_ADD, pick_operand());
        send_token(OP_PUSH, 16'hFFFF);
        send_token(OP_DIV, pick_operand());
        send_token(OP_PUSH, 16'hFFFF);
        send_token(OP_MUL, pick_operand());
        send_token(OP_PUSH, 16'h0001);
        send_token(OP_SUB, pick_operand());
        send_token(OP_PUSH, 16'h0000);
        send_token(OP_DIV, pick_operand());
        send_token(OP_PUSH, 16'hFFF9);
        send_token(OP_PUSH, 16'h0002);
        send_token(OP_DIV, pick_operand());
        send_token(OP_PUSH, 16'd300);
        send_token(OP_PUSH, 16'd300);
        send_token(OP_MUL, pick_operand());
        send_token(OP_SHOW, pick_operand());
        empty_stack();
    endtask

    task automatic test_full_stack();
        while (calc_depth < STACK_DEPTH_DEF) send_token(OP_PUSH, pick_operand());
        repeat (3) send_token(OP_PUSH, pick_operand());
        send_token(OP_SHOW, pick_operand());
        send_token(OP_SUB, pick_operand());
        send_token(OP_PUSH, pick_operand());
        send_token(OP_PUSH, pick_operand());
        send_token(OP_MUL, pick_operand());
        send_token(OP_DIV, pick_operand());
        empty_stack();
    endtask

    task automatic test_random_tokens(input int n_tokens, input int push_pct);
        int roll;
        for (int k = 0; k < n_tokens; k++) begin
            roll = $urandom_range(99);
            if (roll < 6)
                send_token(OPC_W'($urandom_range(7)), DATA_W'($urandom_range(16'hFFFF)));
            else if (roll < 9)
                send_token(OP_SHOW, pick_operand());
            else if (calc_depth < 2 || $urandom_range(99) < push_pct)
                send_token(OP_PUSH, pick_operand());
            else
                send_token(OPC_W'(OP_ADD + $urandom_range(3)), pick_operand());
        end
    endtask

    task automatic test_back_to_back();
        sender_idles = 1'b0;
        test_random_tokens(200, 50);
        sender_idles = 1'b1;
    endtask

    initial begin
        wait (i_rst_n);
        test_empty_stack_faults();
        wait_drained();
        test_arithmetic_corners();
        test_full_stack();
        wait_drained();
        test_random_tokens(300, 55);
        test_back_to_back();
        wait_drained();
        test_random_tokens(150, 70);
        test_random_tokens(100, 40);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/rsc_pkg.sv
sv/rsc_stack_ram.sv
sv/rsc_alu.sv
sv/rpn_stack_calculator_top.sv
dv/tb.sv
